// ===== rtl/core/sde_pkg.sv =====
// Shared types, character codes and helpers for the SMTP data extractor.
package sde_pkg;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One run of words caused by a single input byte.
  typedef struct packed {
    logic [1:0] flush_cnt;  // held marker bytes to replay
    logic       emit_byte;  // pass the input byte after the replay
    logic       msg_end;    // end marker completed (run of one word)
    logic [7:0] data;
  } sde_run_t;

  function automatic logic letter_is(input logic [7:0] c, input logic [7:0] upper);
    return (c | CASE_BIT) == (upper | CASE_BIT);
  endfunction

  // Held marker bytes are always LF, '.', CR in that order.
  function automatic logic [7:0] held_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CH_LF;
      2'd1:    b = CH_DOT;
      default: b = CH_CR;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/sde_front.sv =====
// Front end: command/data parser that turns bytes into run descriptors, pushing one only for a byte that causes words.
module sde_front import sde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  output logic       byte_ready_o,
  input  logic [7:0] byte_i,
  input  logic       full_i,
  output logic       push_o,
  output sde_run_t   run_o
);

  typedef enum logic [2:0] {
    MODE_LINE = 3'b001,
    MODE_SKIP = 3'b010,
    MODE_DATA = 3'b100
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [2:0] pos_q, pos_d;
  logic       accept;
  logic       is_lf;
  logic [1:0] dpos;

  assign byte_ready_o = !full_i;
  assign accept       = byte_valid_i && !full_i;
  assign is_lf        = (byte_i == CH_LF);
  assign dpos         = (pos_q > 3'd3) ? 2'd0 : pos_q[1:0];

  always_comb begin
    mode_d          = mode_q;
    pos_d           = pos_q;
    run_o.flush_cnt = 2'd0;
    run_o.emit_byte = 1'b0;
    run_o.msg_end   = 1'b0;
    run_o.data      = byte_i;
    unique case (mode_q)
      MODE_LINE: begin
        priority case (pos_q)
          3'd0: begin
            if (letter_is(byte_i, CH_D)) begin
              pos_d = 3'd1;
            end else if (!is_lf) begin
              mode_d = MODE_SKIP;
            end
          end
          3'd1, 3'd2, 3'd3: begin
            if (letter_is(byte_i, (pos_q == 3'd2) ? CH_T : CH_A)) begin
              pos_d = pos_q + 3'd1;
            end else begin
              pos_d = 3'd0;
              if (!is_lf) mode_d = MODE_SKIP;
            end
          end
          3'd4: begin
            if (is_lf) begin
              mode_d = MODE_DATA;
              pos_d  = 3'd0;
            end else if (byte_i != CH_CR) begin
              mode_d = MODE_SKIP;
              pos_d  = 3'd0;
            end
          end
          default: begin
            pos_d  = 3'd0;
            mode_d = is_lf ? MODE_LINE : MODE_SKIP;
          end
        endcase
      end
      MODE_DATA: begin
        if (is_lf && (dpos == 2'd2 || dpos == 2'd3)) begin
          run_o.msg_end = 1'b1;
          run_o.data    = 8'h00;
          mode_d        = MODE_LINE;
          pos_d         = 3'd0;
        end else if ((dpos == 2'd0 && is_lf) || (dpos == 2'd1 && byte_i == CH_DOT) ||
                     (dpos == 2'd2 && byte_i == CH_CR)) begin
          pos_d = {1'b0, dpos} + 3'd1;
        end else begin
          run_o.flush_cnt = dpos;
          if (is_lf) begin
            pos_d = 3'd1;
          end else begin
            run_o.emit_byte = 1'b1;
            pos_d           = 3'd0;
          end
        end
      end
      default: begin
        if (is_lf) begin
          mode_d = MODE_LINE;
          pos_d  = 3'd0;
        end
      end
    endcase
  end

  assign push_o = accept &&
                  (run_o.msg_end || run_o.emit_byte || (run_o.flush_cnt != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINE;
      pos_q  <= 3'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// ===== rtl/core/sde_queue.sv =====
// Small run descriptor queue between the parser and the word expander.
module sde_queue import sde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sde_run_t run_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output sde_run_t head_o
);

  sde_run_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QCNT_W'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= run_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_o |-> !pop_i) else $error("pop from empty queue");

endmodule

// ===== rtl/core/sde_back.sv =====
// Back end: expands run descriptors into output words through an output register.
module sde_back import sde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  sde_run_t   head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o,
  output logic       out_end_o,
  output logic       out_last_o
);

  logic [1:0] idx_q;
  logic [2:0] run_len;
  logic       word_last;
  logic       load;
  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       end_q, end_d;
  logic       last_q;

  assign run_len   = {1'b0, head_i.flush_cnt} + {2'b00, head_i.emit_byte} +
                     {2'b00, head_i.msg_end};
  assign word_last = ({1'b0, idx_q} + 3'd1) == run_len;
  assign load      = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o     = load && word_last;

  always_comb begin
    if (head_i.msg_end) begin
      data_d = 8'h00;
      end_d  = 1'b1;
    end else if (idx_q < head_i.flush_cnt) begin
      data_d = held_byte(idx_q);
      end_d  = 1'b0;
    end else begin
      data_d = head_i.data;
      end_d  = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      end_q  <= end_d;
      last_q <= word_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      if (load) idx_q <= word_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_end_o   = end_q;
  assign out_last_o  = last_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_end_o) |-> out_last_o) else $error("end word not last");

  a_end_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_end_o) |-> (out_data_o == 8'h00)) else $error("end word data");

endmodule

// ===== rtl/core/smtp_data_extractor.sv =====
// Top level: SMTP client stream parser passing message body words downstream.
// A word reaches the master side through a run queue entry and then the output register.
// Throughput: one input byte per cycle while the run queue is not full;
// one output word per cycle while runs are queued and m_axis_tready is high.
// A broken end marker replays up to three held bytes, so one byte can cause four words.
// A four-entry run queue decouples the parser from the word expander.
// Reset (rst_ni low, async): parser at command line start, queue and output empty.
module smtp_data_extractor import sde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] message_end
  output logic       m_axis_tlast
);

  logic     push, full, pop, head_valid;
  sde_run_t run, head;

  sde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .full_i       (full),
    .push_o       (push),
    .run_o        (run)
  );

  sde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .run_i        (run),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  sde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_end_o    (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== sim/smtp_data_extractor_tb.sv =====
// Self-checking testbench for the SMTP data extractor: byte stream in, body words out.
`timescale 1ns / 1ps

module smtp_data_extractor_tb;
  import sde_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int LATENCY    = 2;
  localparam int LONG_HOLD  = 100;
  localparam int IDLE_LIMIT = 2000;

  typedef enum logic [1:0] {
    PM_LINE = 2'd0,
    PM_SKIP = 2'd1,
    PM_DATA = 2'd2
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       msg_end;
    logic       last;
  } word_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  smtp_data_extractor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state
  parse_mode_e mode_q = PM_LINE;
  logic [2:0]  pos_q  = 3'd0;
  logic [7:0]  held_q [3];

  logic [7:0] pending_bytes [$];
  word_t      expected_words [$];

  int  pushed_cnt   = 0;
  int  accepted_cnt = 0;
  int  words_seen   = 0;
  int  ends_seen    = 0;
  int  error_cnt    = 0;
  int  idle_cycles  = 0;
  bit  no_idle      = 1'b0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;

  function automatic logic same_letter(input logic [7:0] c, input logic [7:0] upper);
    return (c | CASE_BIT) == (upper | CASE_BIT);
  endfunction

  function automatic void predict_words(input logic [7:0] c);
    word_t      run [4];
    int         n;
    logic [2:0] pos;
    logic [7:0] want;
    n   = 0;
    pos = pos_q;
    case (mode_q)
      PM_LINE: begin
        if (pos == 3'd0) begin
          if (same_letter(c, CH_D)) pos = 3'd1;
          else if (c != CH_LF) mode_q = PM_SKIP;
        end else if (pos <= 3'd3) begin
          want = (pos == 3'd2) ? CH_T : CH_A;
          if (same_letter(c, want)) begin
            pos = pos + 3'd1;
          end else begin
            pos = 3'd0;
            if (c != CH_LF) mode_q = PM_SKIP;
          end
        end else if (pos == 3'd4) begin
          if (c == CH_LF) begin
            mode_q = PM_DATA;
            pos    = 3'd0;
          end else if (c != CH_CR) begin
            mode_q = PM_SKIP;
            pos    = 3'd0;
          end
        end else begin
          pos    = 3'd0;
          mode_q = (c == CH_LF) ? PM_LINE : PM_SKIP;
        end
      end
      PM_DATA: begin
        if (pos > 3'd3) pos = 3'd0;
        if (c == CH_LF && (pos == 3'd2 || pos == 3'd3)) begin
          run[n] = '{data: 8'h00, msg_end: 1'b1, last: 1'b0};
          n      = n + 1;
          mode_q = PM_LINE;
          pos    = 3'd0;
        end else if ((pos == 3'd0 && c == CH_LF) || (pos == 3'd1 && c == CH_DOT) ||
                     (pos == 3'd2 && c == CH_CR)) begin
          held_q[pos] = c;
          pos = pos + 3'd1;
        end else begin
          for (int i = 0; i < int'(pos); i++) begin
            run[n] = '{data: held_q[i], msg_end: 1'b0, last: 1'b0};
            n      = n + 1;
          end
          pos = 3'd0;
          if (c == CH_LF) begin
            held_q[0] = c;
            pos       = 3'd1;
          end else begin
            run[n] = '{data: c, msg_end: 1'b0, last: 1'b0};
            n      = n + 1;
          end
        end
      end
      default: begin
        if (c == CH_LF) begin
          mode_q = PM_LINE;
          pos    = 3'd0;
        end
      end
    endcase
    pos_q = pos;
    for (int i = 0; i < n; i++) begin
      run[i].last = (i == n - 1);
      expected_words.push_back(run[i]);
    end
  endfunction

  // byte driver
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_words(s_axis_tdata);
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 11) == 0) begin
          gap_left      <= $urandom_range(0, 15);
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // word receiver
  int stall_left = 0;
  int hold_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left     <= LONG_HOLD - 1;
        hold_done     <= 1'b1;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left    <= $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // word checker
  always @(posedge clk_i) begin
    word_t got;
    word_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{data: m_axis_tdata, msg_end: m_axis_tuser, last: m_axis_tlast};
        words_seen++;
        if (m_axis_tuser === 1'b1) ends_seen++;
        if (expected_words.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected word, expected none, actual data=%02h end=%b last=%b",
                   $time, got.data, got.msg_end, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got.data !== want.data || got.msg_end !== want.msg_end ||
              got.last !== want.last) begin
            error_cnt++;
            $display("%0t: mismatch, expected data=%02h end=%b last=%b, actual data=%02h end=%b last=%b",
                     $time, want.data, want.msg_end, want.last,
                     got.data, got.msg_end, got.last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    pushed_cnt++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] any_case(input logic [7:0] upper);
    return $urandom_range(0, 1) ? (upper | CASE_BIT) : upper;
  endfunction

  task automatic push_junk_line();
    logic [7:0] b;
    int         len;
    case ($urandom_range(0, 3))
      0: push_byte(any_case(CH_D));
      1: begin
        push_byte(any_case(CH_D));
        push_byte(any_case(CH_A));
      end
      2: begin
        push_byte(any_case(CH_D));
        push_byte(any_case(CH_A));
        push_byte(any_case(CH_T));
      end
      default: ;
    endcase
    len = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_LF) b = 8'h20;
      push_byte(b);
    end
    if ($urandom_range(0, 1)) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic push_data_cmd();
    push_byte(any_case(CH_D));
    push_byte(any_case(CH_A));
    push_byte(any_case(CH_T));
    push_byte(any_case(CH_A));
    if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 2)) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic push_message();
    int r;
    repeat ($urandom_range(0, 2)) push_junk_line();
    push_data_cmd();
    repeat ($urandom_range(0, 14)) begin
      r = $urandom_range(0, 99);
      if (r < 25)      push_byte(CH_LF);
      else if (r < 40) push_byte(CH_DOT);
      else if (r < 55) push_byte(CH_CR);
      else             push_byte(8'($urandom_range(0, 255)));
    end
    push_byte(CH_LF);
    push_byte(CH_DOT);
    if ($urandom_range(0, 9) < 7) push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic push_random(input int count);
    int target;
    int r;
    target = pushed_cnt + count;
    while (pushed_cnt < target) begin
      r = $urandom_range(0, 9);
      if (r < 6)      push_message();
      else if (r < 8) push_junk_line();
      else repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_text("\nDA\nDATAZ\ndAtA\r\r\n");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("\n\n.Q\n.\rZ\n.\r\n");
    wait_drained();

    push_random(180);
    hold_req = 1'b1;
    push_random(180);
    while (accepted_cnt != pushed_cnt) @(posedge clk_i);
    no_idle = 1'b1;
    push_random(40);
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Fed %0d bytes, checked %0d words with %0d message ends, %0d mismatches",
             accepted_cnt, words_seen, ends_seen, error_cnt);
    $display("Covered directed marker cases, random sessions, stalls and a long output hold");
    if (error_cnt == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
